FILE: hw/rtl/pihtq_pkg.sv
// Package with the shared types and codes of the point-in-hitbox table query unit.
`default_nettype none

package pihtq_pkg;

    // Width of one coordinate and of one actor id.
    localparam int COORD_W = 16;
    localparam int ID_W    = 8;

    // Width of the input and output stream beats.
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // Field positions inside the input tdata, lowest bit of each field.
    localparam int F_ACTOR    = 0;
    localparam int F_PARTNER  = 8;
    localparam int F_SOLID    = 16;
    localparam int F_PLATFORM = 17;
    localparam int F_POS_X    = 18;
    localparam int F_POS_Y    = 34;
    localparam int F_OFF_XL   = 50;
    localparam int F_OFF_XH   = 66;
    localparam int F_OFF_YT   = 82;
    localparam int F_OFF_YB   = 98;

    // Action codes carried in the input tuser.
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    // Hit kind codes carried in the output tuser.
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_SOLID    = 2'd1,
        KIND_PLATFORM = 2'd2
    } hit_kind_t;

    // One table entry: owner and the four wrapped bounds.
    typedef struct packed {
        logic [ID_W-1:0]    owner;
        logic [COORD_W-1:0] y_bottom;
        logic [COORD_W-1:0] y_top;
        logic [COORD_W-1:0] x_high;
        logic [COORD_W-1:0] x_low;
    } box_entry_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/point_in_hitbox_table_query_unit.sv
// Top level of the point-in-hitbox table query unit: box tables and scan sequencer.
//
// The unit keeps a solid and a platform table of world-space boxes in two memories.
// Items arrive on the s_ stream; the action code travels in s_tuser. A clear or an
// add beat leaves the unit idle, so it is ready again in the next cycle.
// A query beat starts a scan that reads one table entry per cycle from the memory
// read port, solid table first, then platform table, and checks it in a single
// shared compare unit (owner and four signed bound compares). The scan stops at
// the first hit. The result beat carries the hit kind in m_tuser and the hit
// actor in m_tdata, and it is held until m_tready is seen; the unit takes no new
// beat while a query is in flight or its result waits. Clear, add and unused
// action codes give no result beat.
// The freeze_tables register is written on the cfg_ channel, which is always
// ready; while it is set, clear and add beats leave the tables unchanged.
// Reset empties both tables (their fill counts go to zero) and clears the
// freeze register; the memories themselves are not cleared.
`default_nettype none

module point_in_hitbox_table_query_unit #(
    parameter int TABLE_DEPTH  = 256,
    parameter int STRIP_HEIGHT = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata from bit 0: actor_id, partner_id, solid_flag, platform_flag, pos_x,
    // pos_y, off_x_low, off_x_high, off_y_top, off_y_bottom, zero fill.
    input  wire logic [pihtq_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: action.
    input  wire logic [pihtq_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata: hit_actor.
    output logic [pihtq_pkg::M_TDATA_W-1:0]         m_tdata,
    // tuser: hit_kind.
    output logic [pihtq_pkg::M_TUSER_W-1:0]         m_tuser,
    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_data
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = pihtq_pkg::COORD_W;
    localparam int IW    = pihtq_pkg::ID_W;

    // Input field split.
    logic [IW-1:0] in_actor;
    logic [IW-1:0] in_partner;
    logic          in_solid;
    logic          in_platform;
    logic [CW-1:0] in_pos_x;
    logic [CW-1:0] in_pos_y;
    logic [CW-1:0] in_off_xl;
    logic [CW-1:0] in_off_xh;
    logic [CW-1:0] in_off_yt;
    logic [CW-1:0] in_off_yb;

    assign in_actor    = s_tdata[pihtq_pkg::F_ACTOR +: IW];
    assign in_partner  = s_tdata[pihtq_pkg::F_PARTNER +: IW];
    assign in_solid    = s_tdata[pihtq_pkg::F_SOLID];
    assign in_platform = s_tdata[pihtq_pkg::F_PLATFORM];
    assign in_pos_x    = s_tdata[pihtq_pkg::F_POS_X +: CW];
    assign in_pos_y    = s_tdata[pihtq_pkg::F_POS_Y +: CW];
    assign in_off_xl   = s_tdata[pihtq_pkg::F_OFF_XL +: CW];
    assign in_off_xh   = s_tdata[pihtq_pkg::F_OFF_XH +: CW];
    assign in_off_yt   = s_tdata[pihtq_pkg::F_OFF_YT +: CW];
    assign in_off_yb   = s_tdata[pihtq_pkg::F_OFF_YB +: CW];

    // Registers.
    pihtq_pkg::state_t     state_reg, state_next;
    logic                  freeze_reg;
    logic [CNT_W-1:0]      scount_reg, scount_next;
    logic [CNT_W-1:0]      pcount_reg, pcount_next;
    logic                  tbl_reg, tbl_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic                  pend_tbl_reg, pend_tbl_next;
    logic [CW-1:0]         qx_reg, qx_next;
    logic [CW-1:0]         qy_reg, qy_next;
    logic [IW-1:0]         qactor_reg, qactor_next;
    logic [IW-1:0]         qpartner_reg, qpartner_next;
    pihtq_pkg::hit_kind_t  kind_reg, kind_next;
    logic [IW-1:0]         hit_actor_reg, hit_actor_next;

    // Box memories and their registered read data.
    pihtq_pkg::box_entry_t solid_mem [TABLE_DEPTH];
    pihtq_pkg::box_entry_t plat_mem  [TABLE_DEPTH];
    pihtq_pkg::box_entry_t solid_rd_reg;
    pihtq_pkg::box_entry_t plat_rd_reg;

    // Add path: new entries and write enables.
    pihtq_pkg::box_entry_t solid_wr_entry;
    pihtq_pkg::box_entry_t plat_wr_entry;
    logic                  in_beat;
    logic                  solid_we;
    logic                  plat_we;
    logic [CW-1:0]         sum_yt;

    // Scan path.
    logic                  issue;
    logic                  scan_end;
    pihtq_pkg::box_entry_t cand;
    logic                  cand_hit;

    assign s_tready  = (state_reg == pihtq_pkg::ST_IDLE);
    assign m_tvalid  = (state_reg == pihtq_pkg::ST_DONE);
    assign m_tdata   = hit_actor_reg;
    assign m_tuser   = kind_reg;
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;

    // Bound sums wrap to the coordinate width; the platform strip hangs below the top.
    always_comb
    begin
        sum_yt                  = in_pos_y + in_off_yt;
        solid_wr_entry.owner    = in_actor;
        solid_wr_entry.x_low    = in_pos_x + in_off_xl;
        solid_wr_entry.x_high   = in_pos_x + in_off_xh;
        solid_wr_entry.y_top    = sum_yt;
        solid_wr_entry.y_bottom = in_pos_y + in_off_yb;
        plat_wr_entry           = solid_wr_entry;
        plat_wr_entry.y_bottom  = sum_yt - CW'(STRIP_HEIGHT);
    end

    // An add writes a table only when unfrozen, flagged and not full.
    assign solid_we = in_beat && (s_tuser == pihtq_pkg::ACT_ADD) && !freeze_reg
                      && in_solid && (scount_reg < CNT_W'(TABLE_DEPTH));
    assign plat_we  = in_beat && (s_tuser == pihtq_pkg::ACT_ADD) && !freeze_reg
                      && in_platform && (pcount_reg < CNT_W'(TABLE_DEPTH));

    // Solid table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (solid_we)
        begin
            solid_mem[scount_reg[AW-1:0]] <= solid_wr_entry;
        end
        solid_rd_reg <= solid_mem[idx_reg[AW-1:0]];
    end

    // Platform table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (plat_we)
        begin
            plat_mem[pcount_reg[AW-1:0]] <= plat_wr_entry;
        end
        plat_rd_reg <= plat_mem[idx_reg[AW-1:0]];
    end

    // Shared compare unit: owner exclusion and inclusive signed bounds.
    always_comb
    begin
        issue    = tbl_reg ? (idx_reg < pcount_reg) : (idx_reg < scount_reg);
        scan_end = tbl_reg && !issue;
        cand     = pend_tbl_reg ? plat_rd_reg : solid_rd_reg;
        cand_hit = pend_vld_reg
                   && (cand.owner != qactor_reg)
                   && (cand.owner != qpartner_reg)
                   && ($signed(cand.x_high) >= $signed(qx_reg))
                   && ($signed(qx_reg) >= $signed(cand.x_low))
                   && ($signed(cand.y_top) >= $signed(qy_reg))
                   && ($signed(qy_reg) >= $signed(cand.y_bottom));
    end

    // Sequencer: next state, counts and scan pointers.
    always_comb
    begin
        state_next     = state_reg;
        scount_next    = scount_reg;
        pcount_next    = pcount_reg;
        tbl_next       = tbl_reg;
        idx_next       = idx_reg;
        pend_vld_next  = 1'b0;
        pend_tbl_next  = pend_tbl_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qactor_next    = qactor_reg;
        qpartner_next  = qpartner_reg;
        kind_next      = kind_reg;
        hit_actor_next = hit_actor_reg;

        unique case (state_reg)
            pihtq_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (s_tuser)
                        pihtq_pkg::ACT_CLEAR:
                        begin
                            if (!freeze_reg)
                            begin
                                scount_next = '0;
                                pcount_next = '0;
                            end
                        end
                        pihtq_pkg::ACT_ADD:
                        begin
                            if (solid_we)
                            begin
                                scount_next = scount_reg + CNT_W'(1);
                            end
                            if (plat_we)
                            begin
                                pcount_next = pcount_reg + CNT_W'(1);
                            end
                        end
                        pihtq_pkg::ACT_QUERY:
                        begin
                            qx_next       = in_pos_x;
                            qy_next       = in_pos_y;
                            qactor_next   = in_actor;
                            qpartner_next = in_partner;
                            tbl_next      = 1'b0;
                            idx_next      = '0;
                            state_next    = pihtq_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            // The unused action code is taken and dropped.
                        end
                    endcase
                end
            end
            pihtq_pkg::ST_SCAN:
            begin
                // Issue the next read, or move on to the platform table.
                pend_vld_next = issue;
                pend_tbl_next = tbl_reg;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (!tbl_reg)
                begin
                    tbl_next = 1'b1;
                    idx_next = '0;
                end
                // Check the entry read in the previous cycle.
                if (cand_hit)
                begin
                    kind_next      = pend_tbl_reg ? pihtq_pkg::KIND_PLATFORM
                                                  : pihtq_pkg::KIND_SOLID;
                    hit_actor_next = cand.owner;
                    pend_vld_next  = 1'b0;
                    state_next     = pihtq_pkg::ST_DONE;
                end
                else if (scan_end && !pend_vld_reg)
                begin
                    kind_next      = pihtq_pkg::KIND_NONE;
                    hit_actor_next = '0;
                    state_next     = pihtq_pkg::ST_DONE;
                end
            end
            pihtq_pkg::ST_DONE:
            begin
                if (m_tready)
                begin
                    state_next = pihtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pihtq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pihtq_pkg::ST_IDLE;
            freeze_reg   <= 1'b0;
            scount_reg   <= '0;
            pcount_reg   <= '0;
            tbl_reg      <= 1'b0;
            idx_reg      <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scount_reg   <= scount_next;
            pcount_reg   <= pcount_next;
            tbl_reg      <= tbl_next;
            idx_reg      <= idx_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                freeze_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_tbl_reg  <= pend_tbl_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        qactor_reg    <= qactor_next;
        qpartner_reg  <= qpartner_next;
        kind_reg      <= kind_next;
        hit_actor_reg <= hit_actor_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pihtq_checker.sv
// Port-level checker for the point-in-hitbox table query unit, with its bind.
`default_nettype none

module pihtq_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [pihtq_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [pihtq_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [pihtq_pkg::M_TUSER_W-1:0] m_tuser
);

    // The unit never takes a beat while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    // A query beat blocks the input in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == pihtq_pkg::ACT_QUERY)) |=> !s_tready)
        else $error("input still ready after a query beat");

    // Any other beat leaves the unit ready and gives no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser != pihtq_pkg::ACT_QUERY))
        |=> (s_tready && !m_tvalid))
        else $error("non-query beat stalled the unit or made a result");

    // A miss reports actor zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == pihtq_pkg::KIND_NONE)) |-> (m_tdata == '0))
        else $error("miss with a nonzero actor");

    // Exactly one result beat per query: the result drops after its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result repeated");

endmodule

bind point_in_hitbox_table_query_unit pihtq_checker u_pihtq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the point-in-hitbox table query unit.
module tb;

    // Widths, field positions, codes and types taken from the package.
    localparam int S_TDATA_W  = pihtq_pkg::S_TDATA_W;
    localparam int S_TUSER_W  = pihtq_pkg::S_TUSER_W;
    localparam int M_TDATA_W  = pihtq_pkg::M_TDATA_W;
    localparam int M_TUSER_W  = pihtq_pkg::M_TUSER_W;
    localparam int ID_W       = pihtq_pkg::ID_W;
    localparam int COORD_W    = pihtq_pkg::COORD_W;
    localparam int F_ACTOR    = pihtq_pkg::F_ACTOR;
    localparam int F_PARTNER  = pihtq_pkg::F_PARTNER;
    localparam int F_SOLID    = pihtq_pkg::F_SOLID;
    localparam int F_PLATFORM = pihtq_pkg::F_PLATFORM;
    localparam int F_POS_X    = pihtq_pkg::F_POS_X;
    localparam int F_POS_Y    = pihtq_pkg::F_POS_Y;
    localparam int F_OFF_XL   = pihtq_pkg::F_OFF_XL;
    localparam int F_OFF_XH   = pihtq_pkg::F_OFF_XH;
    localparam int F_OFF_YT   = pihtq_pkg::F_OFF_YT;
    localparam int F_OFF_YB   = pihtq_pkg::F_OFF_YB;

    typedef pihtq_pkg::box_entry_t box_entry_t;
    typedef pihtq_pkg::hit_kind_t  hit_kind_t;

    localparam pihtq_pkg::action_t ACT_CLEAR     = pihtq_pkg::ACT_CLEAR;
    localparam pihtq_pkg::action_t ACT_ADD       = pihtq_pkg::ACT_ADD;
    localparam pihtq_pkg::action_t ACT_QUERY     = pihtq_pkg::ACT_QUERY;
    localparam hit_kind_t          KIND_NONE     = pihtq_pkg::KIND_NONE;
    localparam hit_kind_t          KIND_SOLID    = pihtq_pkg::KIND_SOLID;
    localparam hit_kind_t          KIND_PLATFORM = pihtq_pkg::KIND_PLATFORM;

    localparam int TABLE_DEPTH  = 256;
    localparam int STRIP_HEIGHT = 8;
    localparam int CYCLE_LIMIT  = 3_000_000;
    // A full scan of both tables plus the result stage.
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
    // Clear and add beats finish in the cycle after they are taken.
    localparam int CFG_PAUSE    = 4;

    // Action code that the unit must ignore.
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // One expected result beat.
    typedef struct packed {
        hit_kind_t       kind;
        logic [ID_W-1:0] actor;
    } hit_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = 1'b0;

    // Shadow copy of the box tables and the freeze register.
    box_entry_t  solid_tab [TABLE_DEPTH];
    box_entry_t  platform_tab [TABLE_DEPTH];
    int          solid_fill    = 0;
    int          platform_fill = 0;
    logic        freeze_on     = 1'b0;

    hit_result_t pending_hits [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    point_in_hitbox_table_query_unit #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .STRIP_HEIGHT (STRIP_HEIGHT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random back-pressure and comparison with the oldest expectation.
    always @(posedge clk)
    begin
        hit_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("unexpected result beat: hit_kind %0d, hit_actor %0d", m_tuser, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $error("hit_kind mismatch: expected %0d, actual %0d", want.kind, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata !== want.actor)
                begin
                    $error("hit_actor mismatch: expected %0d, actual %0d", want.actor, m_tdata);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // True when the entry holds the point and belongs to neither excluded actor.
    function automatic bit box_hit(input box_entry_t e, input logic [ID_W-1:0] actor,
                                   input logic [ID_W-1:0] partner,
                                   input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        return e.owner != actor && e.owner != partner &&
               $signed(e.x_high) >= $signed(px) && $signed(px) >= $signed(e.x_low) &&
               $signed(e.y_top) >= $signed(py) && $signed(py) >= $signed(e.y_bottom);
    endfunction

    // Applies one accepted beat to the shadow tables and queues the hit it yields.
    function automatic void apply_box_item(input logic [1:0] act,
                                           input logic [S_TDATA_W-1:0] d);
        logic [ID_W-1:0]    actor;
        logic [ID_W-1:0]    partner;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        box_entry_t         e;
        hit_result_t        res;
        bit                 found;
        actor   = d[F_ACTOR +: ID_W];
        partner = d[F_PARTNER +: ID_W];
        px      = d[F_POS_X +: COORD_W];
        py      = d[F_POS_Y +: COORD_W];
        case (act)
            ACT_CLEAR:
            begin
                if (!freeze_on)
                begin
                    solid_fill    = 0;
                    platform_fill = 0;
                end
            end
            ACT_ADD:
            begin
                if (!freeze_on)
                begin
                    e.owner  = actor;
                    e.x_low  = px + d[F_OFF_XL +: COORD_W];
                    e.x_high = px + d[F_OFF_XH +: COORD_W];
                    e.y_top  = py + d[F_OFF_YT +: COORD_W];
                    if (d[F_SOLID] && solid_fill < TABLE_DEPTH)
                    begin
                        e.y_bottom = py + d[F_OFF_YB +: COORD_W];
                        solid_tab[solid_fill] = e;
                        solid_fill++;
                    end
                    if (d[F_PLATFORM] && platform_fill < TABLE_DEPTH)
                    begin
                        e.y_bottom = e.y_top - COORD_W'(STRIP_HEIGHT);
                        platform_tab[platform_fill] = e;
                        platform_fill++;
                    end
                end
            end
            ACT_QUERY:
            begin
                res.kind  = KIND_NONE;
                res.actor = '0;
                found     = 1'b0;
                for (int i = 0; i < solid_fill; i++)
                begin
                    if (!found && box_hit(solid_tab[i], actor, partner, px, py))
                    begin
                        found     = 1'b1;
                        res.kind  = KIND_SOLID;
                        res.actor = solid_tab[i].owner;
                    end
                end
                for (int i = 0; i < platform_fill; i++)
                begin
                    if (!found && box_hit(platform_tab[i], actor, partner, px, py))
                    begin
                        found     = 1'b1;
                        res.kind  = KIND_PLATFORM;
                        res.actor = platform_tab[i].owner;
                    end
                end
                pending_hits.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(
        input logic [ID_W-1:0] actor, input logic [ID_W-1:0] partner,
        input logic solid, input logic platform,
        input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
        input logic [COORD_W-1:0] oxl, input logic [COORD_W-1:0] oxh,
        input logic [COORD_W-1:0] oyt, input logic [COORD_W-1:0] oyb);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[F_ACTOR +: ID_W]       = actor;
        d[F_PARTNER +: ID_W]     = partner;
        d[F_SOLID]               = solid;
        d[F_PLATFORM]            = platform;
        d[F_POS_X +: COORD_W]    = px;
        d[F_POS_Y +: COORD_W]    = py;
        d[F_OFF_XL +: COORD_W]   = oxl;
        d[F_OFF_XH +: COORD_W]   = oxh;
        d[F_OFF_YT +: COORD_W]   = oyt;
        d[F_OFF_YB +: COORD_W]   = oyb;
        return d;
    endfunction

    // Sends one beat with random gaps in front and predicts it on acceptance.
    task automatic send_beat(input logic [1:0] act, input logic [S_TDATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        apply_box_item(act, d);
    endtask

    // Writes the freeze register once the unit has gone idle.
    task automatic write_freeze(input logic value);
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (CFG_PAUSE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        freeze_on = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] near_coord(input int span);
        return COORD_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [ID_W-1:0] pick_actor();
        if ($urandom_range(9) == 0)
            return ID_W'($urandom_range(255));
        return ID_W'($urandom_range(1, 8));
    endfunction

    // One random beat: mostly adds and queries in a small world, some noise.
    task automatic send_random_item();
        int                 pick;
        bit                 wide;
        logic [ID_W-1:0]    actor;
        logic [ID_W-1:0]    partner;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] oxl;
        logic [COORD_W-1:0] oxh;
        logic [COORD_W-1:0] oyt;
        logic [COORD_W-1:0] oyb;
        logic [1:0]         flags;
        pick  = $urandom_range(99);
        wide  = ($urandom_range(9) == 0);
        actor = pick_actor();
        partner = ($urandom_range(9) < 4) ? actor : pick_actor();
        px    = wide ? COORD_W'($urandom) : near_coord(100);
        py    = wide ? COORD_W'($urandom) : near_coord(100);
        oxl   = wide ? COORD_W'($urandom) : COORD_W'(-int'($urandom_range(20)));
        oxh   = wide ? COORD_W'($urandom) : COORD_W'($urandom_range(20));
        oyt   = wide ? COORD_W'($urandom) : COORD_W'($urandom_range(20));
        oyb   = wide ? COORD_W'($urandom) : COORD_W'(-int'($urandom_range(20)));
        flags = ($urandom_range(19) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
        if (pick < 4)
            send_beat(ACT_CLEAR, pack_item(actor, partner, flags[0], flags[1],
                                           px, py, oxl, oxh, oyt, oyb));
        else if (pick < 7)
            send_beat(ACT_RESERVED, pack_item(actor, partner, flags[0], flags[1],
                                              px, py, oxl, oxh, oyt, oyb));
        else if (pick < 45)
            send_beat(ACT_ADD, pack_item(actor, partner, flags[0], flags[1],
                                         px, py, oxl, oxh, oyt, oyb));
        else
            send_beat(ACT_QUERY, pack_item(actor, partner, flags[0], flags[1],
                                           px, py, oxl, oxh, oyt, oyb));
    endtask

    // Field extremes, exclusion rules, strip edges, wrap and inverted boxes.
    task automatic test_directed_cases();
        send_beat(ACT_CLEAR, '0);
        send_beat(ACT_ADD, pack_item(8'd5, 8'd0, 1'b1, 1'b0, 16'd0, 16'd0,
                                     -16'sd10, 16'sd10, 16'sd10, -16'sd10));
        send_beat(ACT_ADD, pack_item(8'd6, 8'd0, 1'b0, 1'b1, 16'd100, 16'd50,
                                     -16'sd5, 16'sd5, 16'sd0, 16'hFFFF));
        // The upper x bound wraps below the lower one, so this box is empty.
        send_beat(ACT_ADD, pack_item(8'd7, 8'hFF, 1'b1, 1'b1, 16'h7FFF, 16'h8000,
                                     16'd0, 16'd1, 16'd0, 16'd0));
        send_beat(ACT_ADD, pack_item(8'd8, 8'd0, 1'b1, 1'b0, 16'h8000, 16'h7FFF,
                                     16'd0, 16'd0, 16'd0, 16'd0));
        send_beat(ACT_ADD, pack_item(8'd9, 8'd0, 1'b1, 1'b0, 16'd0, 16'd0,
                                     -16'sd2, 16'sd2, 16'sd2, -16'sd2));
        // An add with no table selected changes nothing.
        send_beat(ACT_ADD, pack_item(8'd10, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0,
                                     16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_beat(ACT_ADD, pack_item(8'd255, 8'd255, 1'b1, 1'b1, 16'd300, 16'd300,
                                     16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_beat(ACT_QUERY, pack_item(8'd1, 8'd1, 1'b0, 1'b0, 16'd0, 16'd0,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd5, 8'd5, 1'b0, 1'b0, 16'd0, 16'd0,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd5, 8'd9, 1'b0, 1'b0, 16'd0, 16'd0,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd255, 8'd1, 1'b0, 1'b0, 16'd10, -16'sd10,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd255, 8'd255, 1'b0, 1'b0, 16'd11, 16'd0,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd255, 8'd1, 1'b1, 1'b1, 16'd100, 16'd50,
                                       '1, '1, '1, '1));
        send_beat(ACT_QUERY, pack_item(8'd255, 8'd255, 1'b0, 1'b0, 16'd100, 16'd42,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd255, 8'd255, 1'b0, 1'b0, 16'd100, 16'd41,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd0, 8'd255, 1'b0, 1'b0, 16'h8000, 16'h7FFF,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd0, 8'd0, 1'b0, 1'b0, 16'h7FFF, 16'h8000,
                                       '0, '0, '0, '0));
        send_beat(ACT_RESERVED, '1);
        send_beat(ACT_QUERY, pack_item(8'd0, 8'd0, 1'b0, 1'b0, 16'd300, 16'd300,
                                       '0, '0, '0, '0));
    endtask

    // With the tables frozen, clears and adds must leave them as they are.
    task automatic test_freeze(input int n_random);
        write_freeze(1'b1);
        send_beat(ACT_CLEAR, '0);
        send_beat(ACT_ADD, pack_item(8'd11, 8'd0, 1'b1, 1'b1, 16'd0, 16'd0,
                                     16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_beat(ACT_QUERY, pack_item(8'd1, 8'd1, 1'b0, 1'b0, 16'd0, 16'd0,
                                       '0, '0, '0, '0));
        for (int i = 0; i < n_random; i++)
            send_random_item();
        write_freeze(1'b0);
    endtask

    // Fill both tables to depth, check dropped adds and full-length scans.
    task automatic test_table_full();
        send_beat(ACT_CLEAR, '0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_beat(ACT_ADD, pack_item(ID_W'(i), 8'd0, 1'b1, 1'b0, -16'sd30000, -16'sd30000,
                                         '0, '0, '0, '0));
        // Solid table is full, so this box lands in the platform table alone.
        send_beat(ACT_ADD, pack_item(8'd200, 8'd0, 1'b1, 1'b1, 16'd100, 16'd100,
                                     -16'sd3, 16'sd3, 16'sd3, -16'sd3));
        send_beat(ACT_QUERY, pack_item(8'd1, 8'd1, 1'b0, 1'b0, 16'd100, 16'd100,
                                       '0, '0, '0, '0));
        for (int i = 1; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
                send_beat(ACT_ADD, pack_item(8'd77, 8'd0, 1'b0, 1'b1, 16'd500, 16'd500,
                                             '0, '0, '0, '0));
            else
                send_beat(ACT_ADD, pack_item(ID_W'(i), 8'd0, 1'b0, 1'b1, -16'sd30000,
                                             -16'sd30000, '0, '0, '0, '0));
        end
        send_beat(ACT_ADD, pack_item(8'd201, 8'd0, 1'b1, 1'b1, 16'd0, 16'd0,
                                     -16'sd3, 16'sd3, 16'sd3, -16'sd3));
        send_beat(ACT_QUERY, pack_item(8'd1, 8'd1, 1'b0, 1'b0, 16'd0, 16'd0,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd1, 8'd1, 1'b0, 1'b0, 16'd500, 16'd496,
                                       '0, '0, '0, '0));
        send_beat(ACT_QUERY, pack_item(8'd0, 8'd1, 1'b0, 1'b0, -16'sd30000, -16'sd30000,
                                       '0, '0, '0, '0));
        send_beat(ACT_CLEAR, '0);
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_random_item();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slow sender, heavily stalled receiver.
        send_idle_pct = 13;
        recv_idle_pct = 82;
        test_directed_cases();
        test_freeze(0);
        test_table_full();
        test_random_traffic(100);

        // Bursty receiver, sparse sender.
        send_idle_pct = 82;
        recv_idle_pct = 13;
        test_random_traffic(100);
        test_freeze(40);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);

        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_hits.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
